/* rtl/core/acld_pkg.sv */
package acld_pkg;

   // decoded command codes
   typedef enum logic [3:0] {
      CMD_PING       = 4'd0,
      CMD_ARM        = 4'd1,
      CMD_HEARTBEAT  = 4'd2,
      CMD_STOP_AXIS  = 4'd3,
      CMD_DISARM     = 4'd4,
      CMD_MOVE       = 4'd5,
      CMD_UNKNOWN    = 4'd6,
      CMD_BAD_AXIS   = 4'd7,
      CMD_BAD_FORMAT = 4'd8,
      CMD_TOO_LONG   = 4'd9
   } command_type;

   // keyword slots
   localparam int KW_COUNT     = 8;
   localparam int KW_PING      = 0;
   localparam int KW_STATUS    = 1;
   localparam int KW_ARM       = 2;
   localparam int KW_HB_SAFE   = 3;
   localparam int KW_HB_UNSAFE = 4;
   localparam int KW_DISARM    = 5;
   localparam int KW_STOP      = 6;
   localparam int KW_MOVE      = 7;

   // keyword text, left aligned and padded with spaces to 16 characters
   localparam logic [127:0] KW_TEXT [0:KW_COUNT-1] = '{
      "PING            ",
      "STATUS          ",
      "ARM SAFE        ",
      "HEARTBEAT SAFE  ",
      "HEARTBEAT UNSAFE",
      "DISARM          ",
      "STOP            ",
      "MOVE            "
   };

   localparam logic [4:0] KW_LEN [0:KW_COUNT-1] = '{
      5'd4, 5'd6, 5'd8, 5'd14, 5'd16, 5'd6, 5'd5, 5'd5
   };

   // character codes
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7e;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_1     = 8'h31;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UC_X  = 8'h58;
   localparam logic [7:0] CHAR_UC_Y  = 8'h59;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5a;
   localparam logic [7:0] CHAR_LC_X  = 8'h78;
   localparam logic [7:0] CHAR_LC_Y  = 8'h79;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7a;

   // axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // character at a position of a keyword
   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] p);
      logic [127:0] shifted;
      shifted = KW_TEXT[k] << {p, 3'b000};
      return shifted[127:120];
   endfunction

endpackage

/* rtl/core/ascii_command_line_decoder.sv */
// Decodes ASCII command lines from a byte stream, one byte per clock while
// the result side keeps up, without storing the line: keyword matches are
// tracked per byte and the MOVE axis, direction and two 32-bit decimals are
// parsed as they arrive (decimal digit steps use a constant multiply by ten).
// A byte passes through the input register, and its result, if any, is then
// registered in the result register. A result holds in the result register
// until taken; while it waits the input register still takes one byte. CR or
// LF closing a non-empty line gives one command, the LINE_MAX-th printable
// byte gives line too long and starts a fresh line, other control bytes are
// dropped.
module ascii_command_line_decoder #(
   parameter int LINE_MAX = 160
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_command,
   output logic [1:0]  rsp_axis,
   output logic        rsp_direction,
   output logic [31:0] rsp_step_count,
   output logic [31:0] rsp_rate_hz
);

   localparam int LEN_W = $clog2(LINE_MAX);
   localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_MAX - 1);
   localparam logic [LEN_W-1:0] LEN_ARG  = LEN_W'(5);
   localparam logic [LEN_W-1:0] LEN_STOP_AXIS = LEN_W'(6);
   localparam logic [LEN_W-1:0] LEN_STOP_BARE = LEN_W'(4);

   typedef enum logic [2:0] {
      PH_AXIS       = 3'd0,
      PH_DIR        = 3'd1,
      PH_STEP_START = 3'd2,
      PH_STEP       = 3'd3,
      PH_RATE_START = 3'd4,
      PH_RATE       = 3'd5,
      PH_TRAIL      = 3'd6
   } phase_type;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // line state
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       alive_ff, alive_in;
   phase_type        phase_ff, phase_in;
   logic [1:0]       axis_ff, axis_in;
   logic             axis_bad_ff, axis_bad_in;
   logic             fmt_bad_ff, fmt_bad_in;
   logic             dir_ff, dir_in;
   logic [31:0]      step_ff, step_in;
   logic [31:0]      rate_ff, rate_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   acld_pkg::command_type cmd_ff, cmd_in;
   logic [1:0]           rsp_axis_ff, rsp_axis_in;
   logic                 rsp_dir_ff, rsp_dir_in;
   logic [31:0]          rsp_step_ff, rsp_step_in;
   logic [31:0]          rsp_rate_ff, rsp_rate_in;

   logic        go;
   logic [7:0]  c;
   logic        is_eol, is_print, is_digit, is_space;
   logic [31:0] acc_sel;
   logic [35:0] acc_next;
   logic        acc_ovf;
   logic [7:0]  exact;
   logic        stop_alive, move_alive;
   logic        res_valid;

   // handshakes
   assign go        = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || go;

   assign c        = in_byte_ff;
   assign is_eol   = (c == acld_pkg::CHAR_CR) || (c == acld_pkg::CHAR_LF);
   assign is_print = (c >= acld_pkg::CHAR_SPACE) && (c <= acld_pkg::CHAR_TILDE);
   assign is_digit = (c >= acld_pkg::CHAR_0) && (c <= acld_pkg::CHAR_9);
   assign is_space = (c == acld_pkg::CHAR_SPACE);

   // shared times-ten digit step with overflow detect
   assign acc_sel  = (phase_ff == PH_STEP) ? step_ff : rate_ff;
   assign acc_next = ({4'b0000, acc_sel} << 3) + ({4'b0000, acc_sel} << 1)
                   + {32'd0, c[3:0]};
   assign acc_ovf  = |acc_next[35:32];

   // whole-keyword matches at the current length
   always_comb begin
      for (int k = 0; k < acld_pkg::KW_COUNT; k++) begin
         exact[k] = alive_ff[k] && (len_ff == LEN_W'(acld_pkg::KW_LEN[k]));
      end
   end
   assign stop_alive = alive_ff[acld_pkg::KW_STOP];
   assign move_alive = alive_ff[acld_pkg::KW_MOVE];

   // per-byte update and result decode
   always_comb begin
      len_in      = len_ff;
      alive_in    = alive_ff;
      phase_in    = phase_ff;
      axis_in     = axis_ff;
      axis_bad_in = axis_bad_ff;
      fmt_bad_in  = fmt_bad_ff;
      dir_in      = dir_ff;
      step_in     = step_ff;
      rate_in     = rate_ff;
      res_valid   = 1'b0;
      cmd_in      = acld_pkg::CMD_UNKNOWN;
      rsp_axis_in = 2'd0;
      rsp_dir_in  = 1'b0;
      rsp_step_in = 32'd0;
      rsp_rate_in = 32'd0;

      if (go) begin
         if (is_eol) begin
            if (len_ff != '0) begin
               res_valid = 1'b1;
               // decode in keyword priority order
               priority if (exact[acld_pkg::KW_PING] || exact[acld_pkg::KW_STATUS]) begin
                  cmd_in = acld_pkg::CMD_PING;
               end else if (exact[acld_pkg::KW_ARM]) begin
                  cmd_in = acld_pkg::CMD_ARM;
               end else if (exact[acld_pkg::KW_HB_SAFE]) begin
                  cmd_in = acld_pkg::CMD_HEARTBEAT;
               end else if (stop_alive && len_ff == LEN_STOP_AXIS) begin
                  if (axis_bad_ff) begin
                     cmd_in = acld_pkg::CMD_BAD_AXIS;
                  end else begin
                     cmd_in      = acld_pkg::CMD_STOP_AXIS;
                     rsp_axis_in = axis_ff;
                  end
               end else if (exact[acld_pkg::KW_HB_UNSAFE] || exact[acld_pkg::KW_DISARM]
                            || (stop_alive && len_ff == LEN_STOP_BARE)) begin
                  cmd_in = acld_pkg::CMD_DISARM;
               end else if (move_alive && len_ff >= LEN_ARG) begin
                  if (axis_bad_ff || phase_ff == PH_AXIS) begin
                     cmd_in = acld_pkg::CMD_BAD_AXIS;
                  end else if (fmt_bad_ff
                               || (phase_ff != PH_RATE && phase_ff != PH_TRAIL)) begin
                     cmd_in = acld_pkg::CMD_BAD_FORMAT;
                  end else begin
                     cmd_in      = acld_pkg::CMD_MOVE;
                     rsp_axis_in = axis_ff;
                     rsp_dir_in  = dir_ff;
                     rsp_step_in = step_ff;
                     rsp_rate_in = rate_ff;
                  end
               end else begin
                  cmd_in = acld_pkg::CMD_UNKNOWN;
               end
               len_in      = '0;
               alive_in    = '1;
               phase_in    = PH_AXIS;
               axis_in     = 2'd0;
               axis_bad_in = 1'b0;
               fmt_bad_in  = 1'b0;
               dir_in      = 1'b0;
               step_in     = 32'd0;
               rate_in     = 32'd0;
            end
         end else if (is_print) begin
            if (len_ff < LEN_LAST) begin
               // keyword tracking
               for (int k = 0; k < acld_pkg::KW_COUNT; k++) begin
                  if (int'(len_ff) < int'(acld_pkg::KW_LEN[k])) begin
                     if (acld_pkg::kw_char(3'(k), len_ff[3:0]) != c) begin
                        alive_in[k] = 1'b0;
                     end
                  end else if (k != acld_pkg::KW_STOP && k != acld_pkg::KW_MOVE) begin
                     alive_in[k] = 1'b0;
                  end
               end
               // stop axis letter, uppercase only
               if (len_ff == LEN_ARG && alive_in[acld_pkg::KW_STOP]) begin
                  priority if (c == acld_pkg::CHAR_UC_X) begin
                     axis_in = acld_pkg::AXIS_X;
                  end else if (c == acld_pkg::CHAR_UC_Y) begin
                     axis_in = acld_pkg::AXIS_Y;
                  end else if (c == acld_pkg::CHAR_UC_Z) begin
                     axis_in = acld_pkg::AXIS_Z;
                  end else begin
                     axis_bad_in = 1'b1;
                  end
               end
               // move argument parser, frozen after the first fault
               if (len_ff >= LEN_ARG && alive_in[acld_pkg::KW_MOVE]
                   && !axis_bad_ff && !fmt_bad_ff) begin
                  unique case (phase_ff)
                     PH_AXIS: begin
                        if (!is_space) begin
                           phase_in = PH_DIR;
                           priority if (c == acld_pkg::CHAR_UC_X || c == acld_pkg::CHAR_LC_X) begin
                              axis_in = acld_pkg::AXIS_X;
                           end else if (c == acld_pkg::CHAR_UC_Y
                                        || c == acld_pkg::CHAR_LC_Y) begin
                              axis_in = acld_pkg::AXIS_Y;
                           end else if (c == acld_pkg::CHAR_UC_Z
                                        || c == acld_pkg::CHAR_LC_Z) begin
                              axis_in = acld_pkg::AXIS_Z;
                           end else begin
                              axis_bad_in = 1'b1;
                              phase_in    = PH_AXIS;
                           end
                        end
                     end
                     PH_DIR: begin
                        if (!is_space) begin
                           if (c == acld_pkg::CHAR_0 || c == acld_pkg::CHAR_1) begin
                              dir_in   = c[0];
                              phase_in = PH_STEP_START;
                           end else begin
                              fmt_bad_in = 1'b1;
                           end
                        end
                     end
                     PH_STEP_START, PH_RATE_START: begin
                        if (!is_space) begin
                           if (!is_digit) begin
                              fmt_bad_in = 1'b1;
                           end else if (phase_ff == PH_STEP_START) begin
                              step_in  = {28'd0, c[3:0]};
                              phase_in = PH_STEP;
                           end else begin
                              rate_in  = {28'd0, c[3:0]};
                              phase_in = PH_RATE;
                           end
                        end
                     end
                     PH_STEP, PH_RATE: begin
                        if (is_digit) begin
                           if (acc_ovf) begin
                              fmt_bad_in = 1'b1;
                           end else if (phase_ff == PH_STEP) begin
                              step_in = acc_next[31:0];
                           end else begin
                              rate_in = acc_next[31:0];
                           end
                        end else if (is_space) begin
                           phase_in = (phase_ff == PH_STEP) ? PH_RATE_START : PH_TRAIL;
                        end else begin
                           fmt_bad_in = 1'b1;
                        end
                     end
                     default: begin
                        if (!is_space) begin
                           fmt_bad_in = 1'b1;
                        end
                     end
                  endcase
               end
               len_in = len_ff + 1'b1;
            end else begin
               // line too long: byte dropped, fresh line
               res_valid   = 1'b1;
               cmd_in      = acld_pkg::CMD_TOO_LONG;
               len_in      = '0;
               alive_in    = '1;
               phase_in    = PH_AXIS;
               axis_in     = 2'd0;
               axis_bad_in = 1'b0;
               fmt_bad_in  = 1'b0;
               dir_in      = 1'b0;
               step_in     = 32'd0;
               rate_in     = 32'd0;
            end
         end
      end
   end

   // input and result register control
   always_comb begin
      in_byte_in = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
         alive_ff     <= '1;
         phase_ff     <= PH_AXIS;
         axis_ff      <= 2'd0;
         axis_bad_ff  <= 1'b0;
         fmt_bad_ff   <= 1'b0;
         dir_ff       <= 1'b0;
         step_ff      <= 32'd0;
         rate_ff      <= 32'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         alive_ff     <= alive_in;
         phase_ff     <= phase_in;
         axis_ff      <= axis_in;
         axis_bad_ff  <= axis_bad_in;
         fmt_bad_ff   <= fmt_bad_in;
         dir_ff       <= dir_in;
         step_ff      <= step_in;
         rate_ff      <= rate_in;
      end
      in_byte_ff <= in_byte_in;
      if (res_valid) begin
         cmd_ff      <= cmd_in;
         rsp_axis_ff <= rsp_axis_in;
         rsp_dir_ff  <= rsp_dir_in;
         rsp_step_ff <= rsp_step_in;
         rsp_rate_ff <= rsp_rate_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_command    = cmd_ff;
   assign rsp_axis       = rsp_axis_ff;
   assign rsp_direction  = rsp_dir_ff;
   assign rsp_step_count = rsp_step_ff;
   assign rsp_rate_hz    = rsp_rate_ff;

endmodule
